>>> design/urde_pkg.sv
// Shared constants, request and result codes, and the CRC-8 byte update
// for the register datagram engine. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package urde_pkg;

    // Request codes on the input channel
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_RXB   = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_OK      = 2'd1;
    localparam logic [1:0] KIND_CRCERR  = 2'd2;
    localparam logic [1:0] KIND_TIMEOUT = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_NODE_ADDR = 2'd0;
    localparam logic [1:0] CFG_ECHO_LEN  = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd2;

    localparam logic [7:0]  SYNC_BYTE     = 8'h05;
    localparam logic [7:0]  WRITE_FLAG    = 8'h80;
    localparam logic [7:0]  CRC_POLY      = 8'h07;
    localparam logic [2:0]  ECHO_RESET    = 3'd4;
    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
    localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

    // Reply layout after the echo: 7 payload bytes, value in bytes 3..6, CRC last
    localparam logic [3:0] REPLY_BODY  = 4'd7;
    localparam logic [3:0] VALUE_START = 4'd3;

    // Result counts per request
    localparam logic [3:0] WRITE_RESULTS = 4'd8;
    localparam logic [3:0] READ_RESULTS  = 4'd4;

    // CRC-8, poly 0x07, data fed LSB first
    function automatic logic [7:0] crc_feed(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in;
        for (int b = 0; b < 8; b++) begin
            if (crc[7] ^ data[b]) begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

>>> design/uart_register_datagram_engine.sv
// Register datagram engine: builds write/read datagrams with CRC-8 and checks
// read replies. Depends on urde_pkg.
// The request passes the input register, the burst registers and the output register
// before its first result is valid. One result per cycle while i_out_ready is high;
// a write gives 8 results, a read 4, a reply end or timeout 1, other items none. The
// next request is taken while the last result of a burst goes out.
// Reset (i_rst_n low, synchronous): no read pending, buffers empty, config at
// node 0, echo length 4, timeout 2000 ticks.
`timescale 1ns / 1ps
`default_nettype none

module uart_register_datagram_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [6:0]  i_reg_addr,
    input  wire logic [31:0] i_write_value,
    input  wire logic [7:0]  i_rx_byte,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_out_kind,
    output logic [7:0]       o_tx_byte,
    output logic [31:0]      o_read_value,
    output logic             o_last
);

    // configuration
    logic [3:0]  r_node_addr;
    logic [2:0]  r_echo_len;
    logic [15:0] r_timeout;

    // input register
    logic        r_in_valid;
    logic [1:0]  r_req_type;
    logic [6:0]  r_reg_addr;
    logic [31:0] r_write_value;
    logic [7:0]  r_rx_byte;

    // reply tracking state
    logic        r_pending, n_pending;
    logic [3:0]  r_rx_count, n_rx_count;
    logic [7:0]  r_rx_crc, n_rx_crc;
    logic [31:0] r_rx_value, n_rx_value;
    logic [15:0] r_elapsed, n_elapsed;

    // result burst
    logic [3:0]       r_left;
    logic [1:0]       r_burst_kind;
    logic [31:0]      r_burst_value;
    logic [6:0][7:0]  r_buf;
    logic [7:0]       r_tx_crc;

    // output register
    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [7:0]  r_out_tx;
    logic [31:0] r_out_value;
    logic        r_out_last;

    logic        out_load;
    logic        burst_free;
    logic        proc;
    logic        cur_is_crc;
    logic [7:0]  cur_tx;

    // burst load produced by processing the held request
    logic             ld_burst;
    logic [3:0]       ld_left;
    logic [1:0]       ld_kind;
    logic [31:0]      ld_value;
    logic [6:0][7:0]  ld_buf;

    logic [3:0]  pos;
    logic [15:0] tick_count;

    assign out_load   = (r_left != 4'd0) && (!r_out_valid || i_out_ready);
    assign burst_free = (r_left == 4'd0) || ((r_left == 4'd1) && out_load);
    assign proc       = r_in_valid && burst_free;
    assign o_in_ready = !r_in_valid || proc;

    // CRC byte closes a transmit burst
    assign cur_is_crc = (r_left == 4'd1);
    assign cur_tx     = cur_is_crc ? r_tx_crc : r_buf[0];

    assign pos        = r_rx_count - {1'b0, r_echo_len};
    assign tick_count = (r_elapsed != urde_pkg::TICKS_MAX) ? r_elapsed + 16'd1 : r_elapsed;

    always_comb begin
        n_pending  = r_pending;
        n_rx_count = r_rx_count;
        n_rx_crc   = r_rx_crc;
        n_rx_value = r_rx_value;
        n_elapsed  = r_elapsed;
        ld_burst   = 1'b0;
        ld_left    = 4'd0;
        ld_kind    = urde_pkg::KIND_TX;
        ld_value   = 32'd0;
        ld_buf     = '0;
        case (r_req_type)
            urde_pkg::REQ_WRITE: begin
                ld_burst = 1'b1;
                ld_left  = urde_pkg::WRITE_RESULTS;
                ld_buf   = {r_write_value[7:0], r_write_value[15:8],
                            r_write_value[23:16], r_write_value[31:24],
                            urde_pkg::WRITE_FLAG | {1'b0, r_reg_addr},
                            {4'd0, r_node_addr}, urde_pkg::SYNC_BYTE};
            end
            urde_pkg::REQ_READ: begin
                ld_burst   = 1'b1;
                ld_left    = urde_pkg::READ_RESULTS;
                ld_buf     = {32'd0, {1'b0, r_reg_addr}, {4'd0, r_node_addr},
                              urde_pkg::SYNC_BYTE};
                n_pending  = 1'b1;
                n_rx_count = 4'd0;
                n_rx_crc   = 8'd0;
                n_rx_value = 32'd0;
                n_elapsed  = 16'd0;
            end
            urde_pkg::REQ_RXB: begin
                if (r_pending) begin
                    if (r_rx_count < {1'b0, r_echo_len}) begin
                        // still swallowing our own echo
                        n_rx_count = r_rx_count + 4'd1;
                    end else if (pos < urde_pkg::REPLY_BODY) begin
                        n_rx_crc = urde_pkg::crc_feed(r_rx_crc, r_rx_byte);
                        if (pos >= urde_pkg::VALUE_START) begin
                            n_rx_value = {r_rx_value[23:0], r_rx_byte};
                        end
                        n_rx_count = r_rx_count + 4'd1;
                    end else begin
                        n_pending = 1'b0;
                        ld_burst  = 1'b1;
                        ld_left   = 4'd1;
                        if (r_rx_crc == r_rx_byte) begin
                            ld_kind  = urde_pkg::KIND_OK;
                            ld_value = r_rx_value;
                        end else begin
                            ld_kind  = urde_pkg::KIND_CRCERR;
                        end
                    end
                end
            end
            urde_pkg::REQ_TICK: begin
                if (r_pending) begin
                    n_elapsed = tick_count;
                    if (tick_count >= r_timeout) begin
                        n_pending = 1'b0;
                        ld_burst  = 1'b1;
                        ld_left   = 4'd1;
                        ld_kind   = urde_pkg::KIND_TIMEOUT;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_addr <= 4'd0;
            r_echo_len  <= urde_pkg::ECHO_RESET;
            r_timeout   <= urde_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                urde_pkg::CFG_NODE_ADDR: r_node_addr <= i_cfg_data[3:0];
                urde_pkg::CFG_ECHO_LEN:  r_echo_len  <= i_cfg_data[2:0];
                urde_pkg::CFG_TIMEOUT:   r_timeout   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req_type    <= i_req_type;
            r_reg_addr    <= i_reg_addr;
            r_write_value <= i_write_value;
            r_rx_byte     <= i_rx_byte;
        end
    end

    // reply state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= 1'b0;
            r_rx_count <= 4'd0;
            r_rx_crc   <= 8'd0;
            r_rx_value <= 32'd0;
            r_elapsed  <= 16'd0;
        end else if (proc) begin
            r_pending  <= n_pending;
            r_rx_count <= n_rx_count;
            r_rx_crc   <= n_rx_crc;
            r_rx_value <= n_rx_value;
            r_elapsed  <= n_elapsed;
        end
    end

    // burst sequencer: shifts datagram bytes out, running CRC alongside
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 4'd0;
        end else if (proc && ld_burst) begin
            r_left <= ld_left;
        end else if (out_load) begin
            r_left <= r_left - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && ld_burst) begin
            r_burst_kind  <= ld_kind;
            r_burst_value <= ld_value;
            r_buf         <= ld_buf;
            r_tx_crc      <= 8'd0;
        end else if (out_load) begin
            r_buf    <= {8'd0, r_buf[6:1]};
            r_tx_crc <= urde_pkg::crc_feed(r_tx_crc, r_buf[0]);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_kind  <= r_burst_kind;
            r_out_tx    <= (r_burst_kind == urde_pkg::KIND_TX) ? cur_tx : 8'd0;
            r_out_value <= r_burst_value;
            r_out_last  <= cur_is_crc;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_kind   = r_out_kind;
    assign o_tx_byte    = r_out_tx;
    assign o_read_value = r_out_value;
    assign o_last       = r_out_last;

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench for uart_register_datagram_engine: directed and random request traffic
// checked result by result against a behavioral predictor of the engine.
// Depends on urde_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx;
        logic [31:0] value;
        logic        last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type = '0;
    logic [6:0]  i_reg_addr = '0;
    logic [31:0] i_write_value = '0;
    logic [7:0]  i_rx_byte = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_out_kind;
    logic [7:0]  o_tx_byte;
    logic [31:0] o_read_value;
    logic        o_last;

    // predicted engine state
    logic [3:0]  cfg_node = 4'h0;
    logic [2:0]  cfg_echo = urde_pkg::ECHO_RESET;
    logic [15:0] cfg_timeout = urde_pkg::TIMEOUT_RESET;
    bit          rd_pending = 1'b0;
    logic [3:0]  rd_count = '0;
    logic [7:0]  rd_crc = '0;
    logic [31:0] rd_value = '0;
    logic [15:0] rd_ticks = '0;

    t_result     predicted_q[$];
    int          mismatch_count = 0;
    int          work_items = 0;
    int          tx_idle_pct = 10;
    int          rx_idle_pct = 68;
    int          hold_left = 0;
    int          cycle_count = 0;

    uart_register_datagram_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_reg_addr    (i_reg_addr),
        .i_write_value (i_write_value),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_kind    (o_out_kind),
        .o_tx_byte     (o_tx_byte),
        .o_read_value  (o_read_value),
        .o_last        (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // CRC-8 poly 0x07, each byte shifted in LSB first
    function automatic logic [7:0] crc8_lsb_first(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            c = (c << 1) ^ ((c[7] ^ data[i]) ? urde_pkg::CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic void push_frame(input logic [6:0][7:0] frame, input int n);
        logic [7:0] crc;
        crc = 8'h00;
        for (int i = 0; i < n; i++) begin
            crc = crc8_lsb_first(crc, frame[i]);
            predicted_q.push_back(t_result'{urde_pkg::KIND_TX, frame[i], 32'h0, 1'b0});
        end
        predicted_q.push_back(t_result'{urde_pkg::KIND_TX, crc, 32'h0, 1'b1});
    endfunction

    // Returns 0 when the request is dropped without effect.
    function automatic bit engine_predict(input logic [1:0] req, input logic [6:0] reg_a,
                                          input logic [31:0] wval, input logic [7:0] rxb);
        logic [6:0][7:0] frame;
        logic [3:0]      pos;
        frame = '0;
        frame[0] = urde_pkg::SYNC_BYTE;
        frame[1] = {4'h0, cfg_node};
        if (req == urde_pkg::REQ_WRITE) begin
            frame[2] = urde_pkg::WRITE_FLAG | {1'b0, reg_a};
            frame[3] = wval[31:24];
            frame[4] = wval[23:16];
            frame[5] = wval[15:8];
            frame[6] = wval[7:0];
            push_frame(frame, 7);
            return 1'b1;
        end
        if (req == urde_pkg::REQ_READ) begin
            frame[2] = {1'b0, reg_a};
            rd_pending = 1'b1;
            rd_count = '0;
            rd_crc = '0;
            rd_value = '0;
            rd_ticks = '0;
            push_frame(frame, 3);
            return 1'b1;
        end
        if (!rd_pending) begin
            return 1'b0;
        end
        if (req == urde_pkg::REQ_RXB) begin
            if (rd_count < {1'b0, cfg_echo}) begin
                rd_count = rd_count + 4'd1;
                return 1'b1;
            end
            pos = rd_count - {1'b0, cfg_echo};
            if (pos < urde_pkg::REPLY_BODY) begin
                rd_crc = crc8_lsb_first(rd_crc, rxb);
                if (pos >= urde_pkg::VALUE_START) begin
                    rd_value = {rd_value[23:0], rxb};
                end
                rd_count = rd_count + 4'd1;
                return 1'b1;
            end
            rd_pending = 1'b0;
            if (rd_crc == rxb) begin
                predicted_q.push_back(t_result'{urde_pkg::KIND_OK, 8'h00, rd_value, 1'b1});
            end else begin
                predicted_q.push_back(t_result'{urde_pkg::KIND_CRCERR, 8'h00, 32'h0, 1'b1});
            end
            return 1'b1;
        end
        if (rd_ticks != urde_pkg::TICKS_MAX) begin
            rd_ticks = rd_ticks + 16'd1;
        end
        if (rd_ticks >= cfg_timeout) begin
            rd_pending = 1'b0;
            predicted_q.push_back(t_result'{urde_pkg::KIND_TIMEOUT, 8'h00, 32'h0, 1'b1});
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        end
    endtask

    // Valid is left high after acceptance; the next call or wait_idle decides its level.
    task automatic send_req(input logic [1:0] req, input logic [6:0] reg_a,
                            input logic [31:0] wval, input logic [7:0] rxb);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= req;
        i_reg_addr    <= reg_a;
        i_write_value <= wval;
        i_rx_byte     <= rxb;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (engine_predict(req, reg_a, wval, rxb)) begin
            work_items++;
        end
    endtask

    task automatic send_write(input logic [6:0] reg_a, input logic [31:0] wval);
        send_req(urde_pkg::REQ_WRITE, reg_a, wval, 8'($urandom));
    endtask

    task automatic send_read(input logic [6:0] reg_a);
        send_req(urde_pkg::REQ_READ, reg_a, $urandom, 8'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_req(urde_pkg::REQ_RXB, 7'($urandom), $urandom, b);
    endtask

    task automatic send_tick();
        send_req(urde_pkg::REQ_TICK, 7'($urandom), $urandom, 8'($urandom));
    endtask

    task automatic maybe_tick(input int tick_pct);
        if ($urandom_range(99) < tick_pct) begin
            send_tick();
        end
    endtask

    // Echo bytes, then body_n reply bytes; body_n of 8 includes the CRC byte.
    task automatic send_reply(input int body_n, input bit bad_crc, input int tick_pct);
        logic [7:0] crc;
        logic [7:0] b;
        int         n_echo;
        crc = 8'h00;
        n_echo = cfg_echo;
        for (int i = 0; i < n_echo; i++) begin
            maybe_tick(tick_pct);
            send_byte(8'($urandom));
        end
        for (int i = 0; i < body_n && i < 7; i++) begin
            b = 8'($urandom);
            crc = crc8_lsb_first(crc, b);
            maybe_tick(tick_pct);
            send_byte(b);
        end
        if (body_n > 7) begin
            b = bad_crc ? crc ^ 8'($urandom_range(255, 1)) : crc;
            maybe_tick(tick_pct);
            send_byte(b);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (predicted_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            urde_pkg::CFG_NODE_ADDR: cfg_node = data[3:0];
            urde_pkg::CFG_ECHO_LEN:  cfg_echo = data[2:0];
            urde_pkg::CFG_TIMEOUT:   cfg_timeout = data;
            default: ;
        endcase
    endtask

    // unused upper bits carry random data to check the masking
    task automatic apply_config(input logic [3:0] node, input logic [2:0] echo,
                                input logic [15:0] tmo);
        logic [15:0] d;
        wait_idle();
        d = 16'($urandom);
        d[3:0] = node;
        write_cfg(urde_pkg::CFG_NODE_ADDR, d);
        d = 16'($urandom);
        d[2:0] = echo;
        write_cfg(urde_pkg::CFG_ECHO_LEN, d);
        write_cfg(urde_pkg::CFG_TIMEOUT, tmo);
    endtask

    task automatic test_write_extremes();
        send_write(7'h00, 32'h0000_0000);
        apply_config(4'hF, cfg_echo, urde_pkg::TIMEOUT_RESET);
        send_write(7'h7F, 32'hFFFF_FFFF);
        wait_idle();
    endtask

    // bytes and ticks with no read outstanding are dropped
    task automatic test_idle_traffic();
        send_byte(8'hFF);
        send_byte(8'h00);
        send_tick();
        wait_idle();
    endtask

    task automatic test_zero_timeout();
        apply_config(4'h0, urde_pkg::ECHO_RESET, 16'd0);
        send_read(7'h7F);
        send_tick();
        wait_idle();
    endtask

    // timeout lowered to the elapsed count fires on the next tick
    task automatic test_lowered_timeout();
        apply_config(4'h3, urde_pkg::ECHO_RESET, 16'hFFFF);
        send_read(7'h00);
        send_tick();
        send_tick();
        apply_config(4'h3, urde_pkg::ECHO_RESET, 16'd2);
        send_tick();
        wait_idle();
    endtask

    // longest echo; a second read abandons the first, a write leaves the read armed
    task automatic test_restart_and_write_mid_reply();
        apply_config(4'hA, 3'd7, 16'd100);
        send_read(7'h12);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        send_read(7'h34);
        send_write(7'h55, $urandom);
        send_reply(8, 1'b0, 0);
        wait_idle();
    endtask

    task automatic test_crc_error();
        apply_config(4'h5, 3'd0, 16'd100);
        send_read(7'h21);
        send_reply(8, 1'b1, 0);
        wait_idle();
    endtask

    // receiver holds off while writes keep coming, so the input stalls
    task automatic test_input_backpressure();
        tx_idle_pct = 0;
        apply_config(4'($urandom), 3'd3, 16'd1);
        hold_left = 300;
        repeat (20) send_write(7'($urandom), $urandom);
        send_read(7'($urandom));
        send_tick();
        wait_idle();
    endtask

    task automatic run_mixed_traffic(input int n);
        int stop_at;
        int pick;
        int cut;
        stop_at = work_items + n;
        while (work_items < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                send_write(7'($urandom), $urandom);
            end else if (pick < 80) begin
                send_read(7'($urandom));
                cut = $urandom_range(99);
                if (cut < 75) begin
                    send_reply(8, 1'b0, 8);
                end else if (cut < 90) begin
                    send_reply(8, 1'b1, 8);
                end else begin
                    // cut-off reply: tick it out when the timeout is short
                    send_reply($urandom_range(7), 1'b0, 0);
                    if (cfg_timeout <= 16'd64) begin
                        while (rd_pending) send_tick();
                    end
                end
            end else if (pick < 92) begin
                send_req(2'($urandom), 7'($urandom), $urandom, 8'($urandom));
            end else begin
                send_byte(8'($urandom));
                send_tick();
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (predicted_q.size() == 0) begin
                report_mismatch("unexpected result, kind", 32'(o_out_kind), 32'h0);
            end else begin
                want = predicted_q.pop_front();
                if (o_out_kind !== want.kind) begin
                    report_mismatch("out_kind", 32'(o_out_kind), 32'(want.kind));
                end
                if (o_tx_byte !== want.tx) begin
                    report_mismatch("tx_byte", 32'(o_tx_byte), 32'(want.tx));
                end
                if (o_read_value !== want.value) begin
                    report_mismatch("read_value", o_read_value, want.value);
                end
                if (o_last !== want.last) begin
                    report_mismatch("last", 32'(o_last), 32'(want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_write_extremes();
        test_idle_traffic();
        test_zero_timeout();
        test_lowered_timeout();
        test_restart_and_write_mid_reply();
        test_crc_error();

        tx_idle_pct = 10;
        rx_idle_pct = 68;
        apply_config(4'h0, 3'd0, 16'd40);
        run_mixed_traffic(125);

        test_input_backpressure();

        tx_idle_pct = 68;
        rx_idle_pct = 10;
        apply_config(4'hF, 3'd7, 16'hFFFF);
        run_mixed_traffic(125);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_config(4'($urandom), 3'($urandom), 16'($urandom_range(50, 5)));
        run_mixed_traffic(105);

        wait_idle();
        if (mismatch_count == 0 && predicted_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
